// ----- sv/playfair_digraph_cipher_unit_defines.svh -----
// ----------------------------------------------------------------------------
// playfair digraph cipher unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PDC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// types and constants of the playfair digraph cipher unit
// ----------------------------------------------------------------------------
package pdc_pkg;

  typedef logic [4:0] letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef enum logic [2:0] {
    CMD_KEY    = 3'd0,
    CMD_FINISH = 3'd1,
    CMD_PLAIN  = 3'd2,
    CMD_FLUSH  = 3'd3,
    CMD_CIPHER = 3'd4
  } cmd_e;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam letter_t LET_I    = 5'd8;
  localparam letter_t LET_J    = 5'd9;
  localparam letter_t LET_X    = 5'd23;
  localparam letter_t LET_LAST = 5'd25;

  localparam int NUM_LETTERS = 26;
  localparam int SQ_CELLS    = 25;
  localparam letter_t SQ_LAST = 5'd24;
  localparam logic [2:0] SIDE_LAST = 3'd4;

  localparam logic [NUM_LETTERS-1:0] USED_RESET = 26'h0000200;

endpackage

// ----- sv/playfair_digraph_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// playfair cipher over a 5x5 key square: key entry, plaintext encryption,
// ciphertext decryption, one pair per result
// key letters and pair-opening text letters are handled in the idle state
// a pair-closing letter or flush steps through pos_a, pos_b, cell_f, cell_s, latch, emit
// finish key scans the used bitmap in the fill state, one letter per cycle
// pairs are bound by the single read port of the position and square rams
// reset (rst_n low, synchronous) empties the square, clears the pending letter
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] letter
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] first_letter, [9:5] second_letter
  output logic        out_tuser   // [0] pair_kind
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_A,
    ST_POS_B,
    ST_CELL_F,
    ST_CELL_S,
    ST_LATCH,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [25:0]           used_r, used_nxt;
  pdc_pkg::letter_t      fill_r, fill_nxt;
  logic [2:0]            fill_row_r, fill_row_nxt;
  logic [2:0]            fill_col_r, fill_col_nxt;
  logic                  key_ready_r, key_ready_nxt;
  pdc_pkg::letter_t      held_r, held_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  held_cipher_r, held_cipher_nxt;
  pdc_pkg::letter_t      scan_r, scan_nxt;
  pdc_pkg::letter_t      a_r, a_nxt;
  pdc_pkg::letter_t      b_r, b_nxt;
  logic                  kind_r, kind_nxt;
  pdc_pkg::pos_t         pa_r, pa_nxt;
  pdc_pkg::pos_t         pb_r, pb_nxt;
  pdc_pkg::letter_t      f_r, f_nxt;
  pdc_pkg::letter_t      s_r, s_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pdc_pkg::letter_t      out_first_r, out_first_nxt;
  pdc_pkg::letter_t      out_second_r, out_second_nxt;
  logic                  out_kind_r, out_kind_nxt;

  logic                  accept;
  pdc_pkg::letter_t      lt;
  logic                  lt_ok;
  logic [31:0]           used_ext;
  logic                  place_en;
  pdc_pkg::letter_t      place_lt;
  logic [5:0]            pos_rd;
  pdc_pkg::pos_t         pos_q;
  pdc_pkg::letter_t      pos_raddr;
  pdc_pkg::letter_t      sq_rd;
  pdc_pkg::pos_t         own_pos, other_pos;
  logic [2:0]            cell_row, cell_col;
  pdc_pkg::letter_t      cell_idx;

  function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? pdc_pkg::SIDE_LAST : v - 3'd1;
    end else begin
      r = (v == pdc_pkg::SIDE_LAST) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign lt        = (in_tdata[4:0] == pdc_pkg::LET_J) ? pdc_pkg::LET_I : in_tdata[4:0];
  assign lt_ok     = (lt <= pdc_pkg::LET_LAST);
  assign used_ext  = {6'd0, used_r};
  assign pos_q     = pdc_pkg::pos_t'(pos_rd);

  // shared cell locator, run once for each letter of the pair
  assign own_pos   = (state_r == ST_CELL_S) ? pb_r : pa_r;
  assign other_pos = (state_r == ST_CELL_S) ? pa_r : pos_q;

  always_comb begin
    if (own_pos.row == other_pos.row) begin
      cell_row = own_pos.row;
      cell_col = step5(own_pos.col, kind_r);
    end else if (own_pos.col == other_pos.col) begin
      cell_row = step5(own_pos.row, kind_r);
      cell_col = own_pos.col;
    end else begin
      cell_row = own_pos.row;
      cell_col = other_pos.col;
    end
    cell_idx = {cell_row, 2'b00} + 5'(cell_row) + 5'(cell_col);
  end

  assign pos_raddr = (state_r == ST_POS_B) ? b_r : a_r;

  pdc_ram #(.WIDTH(6), .DEPTH(pdc_pkg::NUM_LETTERS)) u_pos_ram (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (place_lt),
    .wr_data ({fill_row_r, fill_col_r}),
    .rd_addr (pos_raddr),
    .rd_data (pos_rd)
  );

  pdc_ram #(.WIDTH(5), .DEPTH(pdc_pkg::SQ_CELLS)) u_sq_ram (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (fill_r),
    .wr_data (place_lt),
    .rd_addr (cell_idx),
    .rd_data (sq_rd)
  );

  always_comb begin
    state_nxt       = state_r;
    used_nxt        = used_r;
    fill_nxt        = fill_r;
    fill_row_nxt    = fill_row_r;
    fill_col_nxt    = fill_col_r;
    key_ready_nxt   = key_ready_r;
    held_nxt        = held_r;
    held_valid_nxt  = held_valid_r;
    held_cipher_nxt = held_cipher_r;
    scan_nxt        = scan_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    kind_nxt        = kind_r;
    pa_nxt          = pa_r;
    pb_nxt          = pb_r;
    f_nxt           = f_r;
    s_nxt           = s_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    out_kind_nxt    = out_kind_r;
    place_en        = 1'b0;
    place_lt        = lt;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_tuser)
            pdc_pkg::CMD_KEY: begin
              if (!key_ready_r && lt_ok && !used_ext[lt] && (fill_r < pdc_pkg::LET_LAST)) begin
                place_en = 1'b1;
              end
            end
            pdc_pkg::CMD_FINISH: begin
              if (!key_ready_r) begin
                scan_nxt  = 5'd0;
                state_nxt = ST_FILL;
              end
            end
            pdc_pkg::CMD_PLAIN: begin
              if (key_ready_r && lt_ok) begin
                if (!held_valid_r || held_cipher_r) begin
                  held_nxt        = lt;
                  held_valid_nxt  = 1'b1;
                  held_cipher_nxt = 1'b0;
                end else if (held_r == lt) begin
                  a_nxt     = held_r;
                  b_nxt     = pdc_pkg::LET_X;
                  kind_nxt  = pdc_pkg::KIND_ENC;
                  state_nxt = ST_POS_A;
                end else begin
                  a_nxt          = held_r;
                  b_nxt          = lt;
                  kind_nxt       = pdc_pkg::KIND_ENC;
                  held_valid_nxt = 1'b0;
                  state_nxt      = ST_POS_A;
                end
              end
            end
            pdc_pkg::CMD_FLUSH: begin
              if (key_ready_r && held_valid_r && !held_cipher_r) begin
                a_nxt          = held_r;
                b_nxt          = pdc_pkg::LET_X;
                kind_nxt       = pdc_pkg::KIND_ENC;
                held_valid_nxt = 1'b0;
                state_nxt      = ST_POS_A;
              end
            end
            pdc_pkg::CMD_CIPHER: begin
              if (key_ready_r && lt_ok) begin
                if (!held_valid_r || !held_cipher_r) begin
                  held_nxt        = lt;
                  held_valid_nxt  = 1'b1;
                  held_cipher_nxt = 1'b1;
                end else begin
                  a_nxt          = held_r;
                  b_nxt          = lt;
                  kind_nxt       = pdc_pkg::KIND_DEC;
                  held_valid_nxt = 1'b0;
                  state_nxt      = ST_POS_A;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        place_lt = scan_r;
        if (!used_ext[scan_r] && (fill_r < pdc_pkg::LET_LAST)) begin
          place_en = 1'b1;
        end
        if (scan_r == pdc_pkg::LET_LAST) begin
          key_ready_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 5'd1;
        end
      end
      ST_POS_A: begin
        state_nxt = ST_POS_B;
      end
      ST_POS_B: begin
        pa_nxt    = pos_q;
        state_nxt = ST_CELL_F;
      end
      ST_CELL_F: begin
        pb_nxt    = pos_q;
        state_nxt = ST_CELL_S;
      end
      ST_CELL_S: begin
        f_nxt     = sq_rd;
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        s_nxt     = sq_rd;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = f_r;
          out_second_nxt = s_r;
          out_kind_nxt   = kind_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (place_en) begin
      used_nxt[place_lt] = 1'b1;
      fill_nxt           = fill_r + 5'd1;
      if (fill_col_r == pdc_pkg::SIDE_LAST) begin
        fill_col_nxt = 3'd0;
        fill_row_nxt = fill_row_r + 3'd1;
      end else begin
        fill_col_nxt = fill_col_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      used_r        <= pdc_pkg::USED_RESET;
      fill_r        <= 5'd0;
      fill_row_r    <= 3'd0;
      fill_col_r    <= 3'd0;
      key_ready_r   <= 1'b0;
      held_r        <= 5'd0;
      held_valid_r  <= 1'b0;
      held_cipher_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      used_r        <= used_nxt;
      fill_r        <= fill_nxt;
      fill_row_r    <= fill_row_nxt;
      fill_col_r    <= fill_col_nxt;
      key_ready_r   <= key_ready_nxt;
      held_r        <= held_nxt;
      held_valid_r  <= held_valid_nxt;
      held_cipher_r <= held_cipher_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    kind_r       <= kind_nxt;
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    f_r          <= f_nxt;
    s_r          <= s_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_kind_r   <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_second_r, out_first_r};
  assign out_tuser  = out_kind_r;

endmodule

// ----- sv/pdc_ram.sv -----
// ----------------------------------------------------------------------------
// pdc_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module pdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/pdc_checker.sv -----
// ----------------------------------------------------------------------------
// pdc_checker
// port-level checks of the playfair digraph cipher unit
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_unit_defines.svh"

module pdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // stalled result transfer holds
  `PDC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // result letters are real letters
  `PDC_ASSERT_NOW(a_out_range, out_tvalid, (out_tdata[4:0] <= pdc_pkg::LET_LAST) && (out_tdata[9:5] <= pdc_pkg::LET_LAST), "result letter out of range")

  // no j ever leaves the square
  `PDC_ASSERT_NOW(a_out_no_j, out_tvalid, (out_tdata[4:0] != pdc_pkg::LET_J) && (out_tdata[9:5] != pdc_pkg::LET_J), "result holds folded letter")

  // a new result is only loaded while the input side is busy
  `PDC_ASSERT_NOW(a_out_busy, $rose(out_tvalid), !$past(in_tready), "result appeared without busy cycle")

  // padding bits stay zero
  `PDC_ASSERT_NOW(a_out_pad, out_tvalid, out_tdata[15:10] == 6'd0, "result padding not zero")

endmodule

bind playfair_digraph_cipher_unit pdc_checker u_pdc_checker (.*);

// ----- dv/playfair_digraph_cipher_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit_test
// self-checking bench for the playfair digraph cipher unit: one key square is
// built per run from directed and random key letters, then plaintext and
// ciphertext runs stream through with random gaps on both sides; every output
// pair is checked against an in-bench model of the key square and pairing
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit_test;
  import pdc_pkg::*;

  localparam int          SQ_SIDE       = SIDE_LAST + 1;
  localparam int unsigned SHIFT_ENC     = 1;
  localparam int unsigned SHIFT_DEC     = SQ_SIDE - 1;
  localparam logic [2:0]  CMD_RSVD_LO   = 3'd5;
  localparam logic [2:0]  CMD_RSVD_HI   = 3'd7;
  localparam letter_t     LET_A         = 5'd0;
  localparam letter_t     LET_L         = 5'd11;
  localparam letter_t     LET_TOP       = 5'd31;
  localparam int          RAND_ITEMS    = 1300;
  localparam int          DRAIN_AT      = 400;
  localparam int          CHOKE_AT      = 700;
  localparam int          CHOKE_CYCLES  = 400;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          MAX_PRINTS    = 50;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    kind;
  } pair_t;

  typedef struct packed {
    logic [2:0] cmd;
    letter_t    letter;
    logic       drain;
  } text_item_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [4:0] letter
  logic [2:0]  in_tuser   = '0;   // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [4:0] first_letter, [9:5] second_letter
  logic        out_tuser;         // [0] pair_kind

  playfair_digraph_cipher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // model state
  letter_t                sq_cell [SQ_CELLS];
  pos_t                   sq_pos  [NUM_LETTERS];
  logic [NUM_LETTERS-1:0] used_map    = USED_RESET;
  int unsigned            fill_n      = 0;
  bit                     key_done    = 1'b0;
  bit                     pend_v      = 1'b0;
  bit                     pend_cipher = 1'b0;
  letter_t                pend_let    = '0;

  text_item_t  stim_q [$];
  pair_t       pair_q [$];
  int          err_count   = 0;
  int          sent_count  = 0;
  int unsigned tx_wait     = 0;
  int unsigned rx_wait     = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  int          choke_left  = 0;
  bit          choke_fired = 1'b0;
  bit          drain_next  = 1'b0;

  task automatic flag_error(string msg);
    if (err_count < MAX_PRINTS)
      $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned gap_draw(bit calm);
    if (calm || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void key_place(int unsigned lt);
    if (fill_n >= SQ_CELLS)
      return;
    sq_cell[fill_n]    = letter_t'(lt);
    sq_pos[lt].row     = 3'(fill_n / SQ_SIDE);
    sq_pos[lt].col     = 3'(fill_n % SQ_SIDE);
    used_map[lt]       = 1'b1;
    fill_n++;
  endfunction

  // row rule shifts along the row, column rule along the column, else swap columns
  function automatic pair_t pair_map(letter_t a, letter_t b, int unsigned shift, logic kind);
    int unsigned r1, c1, r2, c2;
    pair_t p;
    r1 = sq_pos[a].row;
    c1 = sq_pos[a].col;
    r2 = sq_pos[b].row;
    c2 = sq_pos[b].col;
    if (r1 == r2) begin
      p.first  = sq_cell[r1 * SQ_SIDE + (c1 + shift) % SQ_SIDE];
      p.second = sq_cell[r2 * SQ_SIDE + (c2 + shift) % SQ_SIDE];
    end else if (c1 == c2) begin
      p.first  = sq_cell[((r1 + shift) % SQ_SIDE) * SQ_SIDE + c1];
      p.second = sq_cell[((r2 + shift) % SQ_SIDE) * SQ_SIDE + c2];
    end else begin
      p.first  = sq_cell[r1 * SQ_SIDE + c2];
      p.second = sq_cell[r2 * SQ_SIDE + c1];
    end
    p.kind = kind;
    return p;
  endfunction

  function automatic bit cipher_step(logic [2:0] cmd, letter_t lt_in, output pair_t res);
    letter_t lt;
    lt  = (lt_in == LET_J) ? LET_I : lt_in;
    res = '0;
    case (cmd)
      CMD_KEY: begin
        if (!key_done && lt <= LET_LAST && !used_map[lt])
          key_place(lt);
      end
      CMD_FINISH: begin
        if (!key_done) begin
          for (int i = 0; i < NUM_LETTERS; i++)
            if (!used_map[i])
              key_place(i);
          key_done = 1'b1;
        end
      end
      CMD_PLAIN: begin
        if (key_done && lt <= LET_LAST) begin
          if (!pend_v || pend_cipher) begin
            pend_let    = lt;
            pend_v      = 1'b1;
            pend_cipher = 1'b0;
          end else if (pend_let == lt) begin
            // repeated letter: pad with x and keep it pending
            res = pair_map(pend_let, LET_X, SHIFT_ENC, KIND_ENC);
            return 1'b1;
          end else begin
            res    = pair_map(pend_let, lt, SHIFT_ENC, KIND_ENC);
            pend_v = 1'b0;
            return 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        if (key_done && pend_v && !pend_cipher) begin
          res    = pair_map(pend_let, LET_X, SHIFT_ENC, KIND_ENC);
          pend_v = 1'b0;
          return 1'b1;
        end
      end
      CMD_CIPHER: begin
        if (key_done && lt <= LET_LAST) begin
          if (!pend_v || !pend_cipher) begin
            pend_let    = lt;
            pend_v      = 1'b1;
            pend_cipher = 1'b1;
          end else begin
            res    = pair_map(pend_let, lt, SHIFT_DEC, KIND_DEC);
            pend_v = 1'b0;
            return 1'b1;
          end
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic queue_item(logic [2:0] cmd, letter_t lt);
    text_item_t it;
    it.cmd     = cmd;
    it.letter  = lt;
    it.drain   = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin : tx_proc
    pair_t      got;
    text_item_t it;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      tx_wait    <= 0;
      sent_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        sent_count <= sent_count + 1;
        if (cipher_step(in_tuser, in_tdata[4:0], got))
          pair_q.push_back(got);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait != 0) begin
          in_tvalid <= 1'b0;
          tx_wait   <= tx_wait - 1;
        end else if (stim_q.size() != 0 && !(stim_q[0].drain && pair_q.size() != 0)) begin
          it = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= it.cmd;
          in_tdata  <= {3'b000, it.letter};
          tx_wait   <= gap_draw(tx_calm);
          if ($urandom_range(0, 63) == 0)
            tx_calm <= !tx_calm;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      choke_left  <= 0;
      choke_fired <= 1'b0;
    end else if (!choke_fired && sent_count >= CHOKE_AT) begin
      choke_left  <= CHOKE_CYCLES;
      choke_fired <= 1'b1;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : rx_proc
    pair_t       want;
    pair_t       seen;
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else begin
      w = rx_wait;
      if (out_tvalid && out_tready) begin
        seen.first  = out_tdata[4:0];
        seen.second = out_tdata[9:5];
        seen.kind   = out_tuser;
        if (pair_q.size() == 0) begin
          flag_error($sformatf("unexpected pair %0d,%0d kind %0d",
                               seen.first, seen.second, seen.kind));
        end else begin
          want = pair_q.pop_front();
          if (seen.first != want.first)
            flag_error($sformatf("first letter %0d, want %0d", seen.first, want.first));
          if (seen.second != want.second)
            flag_error($sformatf("second letter %0d, want %0d", seen.second, want.second));
          if (seen.kind != want.kind)
            flag_error($sformatf("pair kind %0d, want %0d", seen.kind, want.kind));
        end
        w = gap_draw(rx_calm);
        if ($urandom_range(0, 63) == 0)
          rx_calm <= !rx_calm;
      end
      if (choke_left != 0) begin
        out_tready <= 1'b0;
        rx_wait    <= w;
      end else if (w != 0) begin
        out_tready <= 1'b0;
        rx_wait    <= w - 1;
      end else begin
        out_tready <= 1'b1;
        rx_wait    <= 0;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    int unsigned key_len, run_len, rand_n;
    letter_t     prev, lt;
    bit          drained;
    rand_n  = 0;
    drained = 1'b0;

    // text before the key is finished is dropped
    queue_item(CMD_PLAIN, LET_A);
    queue_item(CMD_FLUSH, LET_A);
    queue_item(CMD_CIPHER, LET_LAST);

    // key entry: j folds to i, repeats and out-of-range letters dropped
    queue_item(CMD_KEY, LET_J);
    queue_item(CMD_KEY, LET_I);
    queue_item(CMD_KEY, LET_LAST);
    queue_item(CMD_KEY, LET_TOP);
    queue_item(CMD_RSVD_HI, LET_A);
    key_len = $urandom_range(0, 24);
    for (int i = 0; i < key_len; i++)
      queue_item(CMD_KEY, letter_t'($urandom_range(0, 31)));
    queue_item(CMD_FINISH, LET_TOP);
    queue_item(CMD_KEY, LET_X);
    queue_item(CMD_FINISH, LET_A);

    // pairing corner cases
    queue_item(CMD_FLUSH, LET_A);
    queue_item(CMD_PLAIN, LET_L);
    queue_item(CMD_PLAIN, LET_L);
    queue_item(CMD_FLUSH, LET_TOP);
    queue_item(CMD_PLAIN, LET_X);
    queue_item(CMD_PLAIN, LET_X);
    queue_item(CMD_FLUSH, LET_A);
    queue_item(CMD_PLAIN, LET_A);
    queue_item(CMD_CIPHER, LET_LAST);
    queue_item(CMD_FLUSH, LET_A);
    queue_item(CMD_PLAIN, LET_TOP);
    queue_item(CMD_CIPHER, LET_J);
    queue_item(CMD_CIPHER, LET_A);
    queue_item(CMD_PLAIN, LET_LAST);
    queue_item(CMD_PLAIN, LET_A);
    queue_item(CMD_CIPHER, LET_X);
    queue_item(CMD_CIPHER, LET_X);
    queue_item(CMD_RSVD_LO, LET_A);
    queue_item(CMD_PLAIN, LET_J);
    queue_item(CMD_FLUSH, LET_A);

    // random runs of text, mostly well formed
    drain_next = 1'b1;
    while (rand_n < RAND_ITEMS) begin
      if (!drained && rand_n >= DRAIN_AT) begin
        drain_next = 1'b1;
        drained    = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          queue_item(3'($urandom_range(0, 7)), letter_t'($urandom_range(0, 31)));
          rand_n++;
        end
        1, 2, 3, 4, 5: begin
          run_len = $urandom_range(1, 12);
          prev    = letter_t'($urandom_range(0, 25));
          for (int i = 0; i < run_len; i++) begin
            lt = ($urandom_range(0, 3) == 0) ? prev : letter_t'($urandom_range(0, 25));
            queue_item(CMD_PLAIN, lt);
            prev = lt;
          end
          rand_n += run_len;
          if ($urandom_range(0, 3) != 0) begin
            queue_item(CMD_FLUSH, letter_t'($urandom_range(0, 31)));
            rand_n++;
          end
        end
        default: begin
          run_len = 2 * $urandom_range(1, 6);
          prev    = letter_t'($urandom_range(0, 25));
          for (int i = 0; i < run_len; i++) begin
            lt = ($urandom_range(0, 7) == 0) ? prev : letter_t'($urandom_range(0, 25));
            queue_item(CMD_CIPHER, lt);
            prev = lt;
          end
          rand_n += run_len;
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() != 0 || in_tvalid || pair_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/pdc_pkg.sv
sv/pdc_ram.sv
sv/playfair_digraph_cipher_unit.sv
sv/pdc_checker.sv
dv/playfair_digraph_cipher_unit_test.sv
